// ===== hw/rtl/float32_truncating_adder_unit_assert.svh =====
// Assertion macros for the float32 truncating adder.
`ifndef FLOAT32_TRUNCATING_ADDER_UNIT_ASSERT_SVH
`define FLOAT32_TRUNCATING_ADDER_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge, off during reset.
`define FTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define FTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/fta_pkg.sv =====
// Package with shared types and constants for the float32 truncating adder.
`default_nettype none
package fta_pkg;
    localparam int unsigned FRAC_W = 23;
    localparam int unsigned EXP_W  = 8;
    localparam int unsigned LZ_W   = 5;

    typedef logic [FRAC_W-1:0] t_mag;
    typedef logic [EXP_W-1:0]  t_exp;

    // stage 1 -> stage 2: aligned magnitudes
    typedef struct packed {
        logic  sign_hi;
        logic  sign_lo;
        t_exp  exp_hi;
        t_mag  mag_hi;
        t_mag  mag_lo;
    } t_align;

    // stage 2 -> stage 3: raw add/subtract result
    typedef struct packed {
        logic        sign;
        logic        is_sub;
        t_exp        exp_hi;
        logic [FRAC_W:0] raw;
    } t_arith;

    // one plus the leading zero count of a 23-bit value; 23 when zero
    function automatic logic [LZ_W-1:0] lead_count(input t_mag v);
        logic [LZ_W-1:0] n;
        logic            hit;
        n   = LZ_W'(FRAC_W);
        hit = 1'b0;
        for (int p = FRAC_W - 1; p >= 0; p--) begin
            if (!hit && v[p]) begin
                n   = LZ_W'(FRAC_W - p);
                hit = 1'b1;
            end
        end
        return n;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/fta_align.sv =====
// Operand swap and alignment shift stage.
`default_nettype none
module fta_align import fta_pkg::*; (
    input  wire  logic [31:0] i_a,
    input  wire  logic [31:0] i_b,
    output t_align           o_align
);
    logic       b_big;
    t_exp       ea, eb, ediff;
    logic [31:0] hi, lo;
    t_mag       ml;
    always_comb begin
        ea    = i_a[30:23];
        eb    = i_b[30:23];
        b_big = eb > ea;
        hi    = b_big ? i_b : i_a;
        lo    = b_big ? i_a : i_b;
        ediff = b_big ? (eb - ea) : (ea - eb);
        ml    = {1'b1, lo[22:1]};
        o_align.sign_hi = hi[31];
        o_align.sign_lo = lo[31];
        o_align.exp_hi  = hi[30:23];
        o_align.mag_hi  = {1'b1, hi[22:1]};
        o_align.mag_lo  = (ediff >= t_exp'(FRAC_W)) ? '0 : (ml >> ediff[4:0]);
    end
endmodule
`default_nettype wire

// ===== hw/rtl/fta_arith.sv =====
// Magnitude add or subtract stage.
`default_nettype none
module fta_arith import fta_pkg::*; (
    input  wire t_align i_align,
    output t_arith      o_arith
);
    logic swap;
    always_comb begin
        swap = i_align.mag_lo > i_align.mag_hi;
        o_arith.exp_hi = i_align.exp_hi;
        o_arith.is_sub = i_align.sign_hi != i_align.sign_lo;
        if (!o_arith.is_sub) begin
            o_arith.sign = i_align.sign_hi;
            o_arith.raw  = {1'b0, i_align.mag_hi} + {1'b0, i_align.mag_lo};
        end else if (swap) begin
            o_arith.sign = i_align.sign_lo;
            o_arith.raw  = {1'b0, i_align.mag_lo - i_align.mag_hi};
        end else begin
            o_arith.sign = i_align.sign_hi;
            o_arith.raw  = {1'b0, i_align.mag_hi - i_align.mag_lo};
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/fta_norm.sv =====
// Normalize and pack stage.
`default_nettype none
module fta_norm import fta_pkg::*; (
    input  wire  t_arith      i_arith,
    output logic [31:0]       o_sum
);
    logic [LZ_W-1:0] lead;
    t_mag            diff, frac;
    t_exp            expo;
    always_comb begin
        diff = i_arith.raw[FRAC_W-1:0];
        lead = lead_count(diff);
        if (!i_arith.is_sub) begin
            if (i_arith.raw[FRAC_W]) begin
                expo = i_arith.exp_hi + 8'd1;
                frac = diff;
            end else begin
                expo = i_arith.exp_hi;
                frac = {diff[FRAC_W-2:0], 1'b0};
            end
        end else if (lead >= LZ_W'(FRAC_W)) begin
            // empty difference, or leading one only at the bottom bit
            expo = '0;
            frac = '0;
        end else begin
            expo = i_arith.exp_hi + 8'd1 - t_exp'(lead);
            frac = diff << lead;
        end
        o_sum = {i_arith.sign, expo, frac};
    end
endmodule
`default_nettype wire

// ===== hw/rtl/float32_truncating_adder_unit.sv =====
// Top level: three-stage pipelined truncating float32 adder.
// Pipeline: 3 register stages; an accepted item passes r_s1, r_s2 and r_s3 to the output.
// Throughput: one item per cycle unless stalled; stage 1 aligns, stage 2 adds or subtracts,
// stage 3 normalizes with a leading-one count and packs.
// Stall holds full stages with no gap after them; empty stages fill (bubble collapse).
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
`default_nettype none
module float32_truncating_adder_unit import fta_pkg::*; (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_valid,
    output logic              o_stall,
    input  wire  logic [31:0] i_operand_a,
    input  wire  logic [31:0] i_operand_b,
    output logic              o_valid,
    input  wire  logic        i_stall,
    output logic [31:0]       o_sum_bits
);
`include "float32_truncating_adder_unit_assert.svh"

    logic   r_v1, r_v2, r_v3;
    t_align r_s1;
    t_arith r_s2;
    logic [31:0] r_s3;

    t_align n_s1;
    t_arith n_s2;
    logic [31:0] n_s3;

    // each stage advances when the one after it is free or moving
    logic adv3, adv2, adv1;
    assign adv3 = !r_v3 || !i_stall;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_stall = !adv1;

    fta_align u_align (.i_a(i_operand_a), .i_b(i_operand_b), .o_align(n_s1));
    fta_arith u_arith (.i_align(r_s1), .o_arith(n_s2));
    fta_norm  u_norm  (.i_arith(r_s2), .o_sum(n_s3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) r_s1 <= n_s1;
        if (adv2) r_s2 <= n_s2;
        if (adv3) r_s3 <= n_s3;
    end

    assign o_valid    = r_v3;
    assign o_sum_bits = r_s3;

    `FTA_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_sum_bits), "output item changed under stall")
    `FTA_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_stall,
        r_v1 && r_v2 && r_v3 && i_stall, "input stalled with room in pipeline")
    `FTA_ASSERT_NEXT(a_move, i_clk, i_rst_n, r_v2 && adv3,
        o_valid, "stage 2 item lost on advance")
endmodule
`default_nettype wire
